[rtl/ppep_pkg.sv]
`timescale 1ns / 1ps

package ppep_pkg;

    // Page geometry and entry capacity
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_ENTRIES = 512;

    // Derived widths
    localparam int POS_W  = $clog2(PAGE_BYTES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);

    // Request queue between parser and result stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field sizes in bytes, as the last byte's count value
    localparam logic [2:0] SHORT_LAST = 3'd1;
    localparam logic [2:0] HASH_LAST  = 3'd7;

    typedef enum logic [5:0] {
        PH_COUNT = 6'b000001,
        PH_INDEX = 6'b000010,
        PH_HASH  = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_SKIP  = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    // One pending result: which stored entry to look up plus its computed fields
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [48:0]      offset;
        logic [15:0]      length;
        logic             last;
        logic             overflow;
    } req_t;

    // Header store write port
    typedef struct packed {
        logic             idx_we;
        logic             hash_we;
        logic [IDX_W-1:0] addr;
        logic [15:0]      idx_data;
        logic [63:0]      hash_data;
    } wr_t;

    // Queue status seen by the parser
    typedef struct packed {
        logic full;
        logic busy;
    } qstat_t;

endpackage

[rtl/ppep_front.sv]
`timescale 1ns / 1ps

module ppep_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic [47:0]           s_page_base,
    input  logic                  s_page_first,
    input  ppep_pkg::qstat_t      qstat,
    output logic                  push,
    output ppep_pkg::req_t        push_req,
    output ppep_pkg::wr_t         wr,
    output logic                  hdr_phase
);

    ppep_pkg::phase_t                 phase_reg, phase_next, phase_e;
    logic [ppep_pkg::POS_W-1:0]       pos_reg, pos_next, pos_e;
    logic [15:0]                      total_reg, total_next, total_e;
    logic [15:0]                      cursor_reg, cursor_next, cursor_e;
    logic [63:0]                      shift_reg, shift_next, shift_e, shift_in;
    logic [2:0]                       cnt_reg, cnt_next, cnt_e;
    logic [15:0]                      skip_reg, skip_next, skip_e;
    logic [47:0]                      base_reg, base_next, base_e;
    logic                             accept;
    logic [15:0]                      field16;
    logic [15:0]                      cursor_inc;
    logic [15:0]                      kept;
    logic [16:0]                      cursor_inc_w;

    // Header phases write the store; hold them off while older lookups are pending
    assign hdr_phase = (phase_reg == ppep_pkg::PH_INDEX) || (phase_reg == ppep_pkg::PH_HASH);
    assign s_ready   = !qstat.full && !(qstat.busy && hdr_phase);
    assign accept    = s_valid && s_ready;

    // State as seen after an optional page restart
    always_comb begin
        if (s_page_first) begin
            phase_e  = ppep_pkg::PH_COUNT;
            pos_e    = '0;
            total_e  = '0;
            cursor_e = '0;
            shift_e  = '0;
            cnt_e    = '0;
            skip_e   = '0;
            base_e   = s_page_base;
        end else begin
            phase_e  = phase_reg;
            pos_e    = pos_reg;
            total_e  = total_reg;
            cursor_e = cursor_reg;
            shift_e  = shift_reg;
            cnt_e    = cnt_reg;
            skip_e   = skip_reg;
            base_e   = base_reg;
        end
    end

    // Little-endian assembly: new byte enters at the top
    assign shift_in     = {s_data_byte, shift_e[63:8]};
    assign field16      = shift_in[63:48];
    assign cursor_inc   = cursor_e + 16'd1;
    assign cursor_inc_w = {1'b0, cursor_e} + 17'd1;
    assign kept         = (total_e > 16'(ppep_pkg::MAX_ENTRIES)) ?
                          16'(ppep_pkg::MAX_ENTRIES) : total_e;

    // Parser step
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        cursor_next = cursor_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        skip_next   = skip_reg;
        base_next   = base_reg;
        push        = 1'b0;
        push_req    = '0;
        wr          = '0;
        wr.addr     = cursor_e[ppep_pkg::IDX_W-1:0];
        wr.idx_data = field16;
        wr.hash_data = shift_in;

        if (accept) begin
            phase_next  = phase_e;
            pos_next    = pos_e;
            total_next  = total_e;
            cursor_next = cursor_e;
            shift_next  = shift_e;
            cnt_next    = cnt_e;
            skip_next   = skip_e;
            base_next   = base_e;

            if (pos_e < ppep_pkg::POS_W'(ppep_pkg::PAGE_BYTES)) begin
                pos_next   = pos_e + ppep_pkg::POS_W'(1);
                shift_next = shift_in;
                cnt_next   = cnt_e + 3'd1;
                unique case (phase_e)
                    ppep_pkg::PH_COUNT: begin
                        if (cnt_e == ppep_pkg::SHORT_LAST) begin
                            total_next  = field16;
                            cursor_next = '0;
                            cnt_next    = '0;
                            phase_next  = (field16 == 16'd0) ? ppep_pkg::PH_DONE
                                                             : ppep_pkg::PH_INDEX;
                        end
                    end
                    ppep_pkg::PH_INDEX: begin
                        if (cnt_e == ppep_pkg::SHORT_LAST) begin
                            wr.idx_we  = cursor_e < 16'(ppep_pkg::MAX_ENTRIES);
                            cnt_next   = '0;
                            phase_next = ppep_pkg::PH_HASH;
                        end
                    end
                    ppep_pkg::PH_HASH: begin
                        if (cnt_e == ppep_pkg::HASH_LAST) begin
                            wr.hash_we = cursor_e < 16'(ppep_pkg::MAX_ENTRIES);
                            cnt_next   = '0;
                            if (cursor_inc >= total_e) begin
                                cursor_next = '0;
                                phase_next  = ppep_pkg::PH_LEN;
                            end else begin
                                cursor_next = cursor_inc;
                                phase_next  = ppep_pkg::PH_INDEX;
                            end
                        end
                    end
                    ppep_pkg::PH_LEN: begin
                        if (cnt_e == ppep_pkg::SHORT_LAST) begin
                            cnt_next          = '0;
                            push              = 1'b1;
                            push_req.idx      = (cursor_e < 16'(ppep_pkg::MAX_ENTRIES)) ?
                                                cursor_e[ppep_pkg::IDX_W-1:0] : '0;
                            push_req.offset   = 49'(base_e) + 49'(pos_e) + 49'd1;
                            push_req.length   = field16;
                            push_req.last     = cursor_inc_w >= {1'b0, kept};
                            push_req.overflow = total_e > 16'(ppep_pkg::MAX_ENTRIES);
                            cursor_next       = cursor_inc;
                            if (push_req.last) begin
                                phase_next = ppep_pkg::PH_DONE;
                            end else if (field16 == 16'd0) begin
                                phase_next = ppep_pkg::PH_LEN;
                            end else begin
                                skip_next  = field16;
                                phase_next = ppep_pkg::PH_SKIP;
                            end
                        end
                    end
                    ppep_pkg::PH_SKIP: begin
                        shift_next = shift_e;
                        cnt_next   = cnt_e;
                        skip_next  = (skip_e != 16'd0) ? skip_e - 16'd1 : skip_e;
                        if (skip_next == 16'd0) begin
                            phase_next = ppep_pkg::PH_LEN;
                        end
                    end
                    ppep_pkg::PH_DONE: begin
                        shift_next = shift_e;
                        cnt_next   = cnt_e;
                    end
                    default: begin
                        shift_next = shift_e;
                        cnt_next   = cnt_e;
                    end
                endcase
            end
        end
    end

    // Parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ppep_pkg::PH_COUNT;
            pos_reg    <= '0;
            total_reg  <= '0;
            cursor_reg <= '0;
            cnt_reg    <= '0;
            skip_reg   <= '0;
            base_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            cursor_reg <= cursor_next;
            cnt_reg    <= cnt_next;
            skip_reg   <= skip_next;
            base_reg   <= base_next;
        end
    end

    // Field assembly register; every field is fully shifted in before use
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule

[rtl/ppep_queue.sv]
`timescale 1ns / 1ps

module ppep_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ppep_pkg::req_t        push_req,
    input  logic                  pop,
    output ppep_pkg::req_t        head,
    output logic                  empty,
    output ppep_pkg::qstat_t      qstat
);

    ppep_pkg::req_t                slot_reg [ppep_pkg::QUEUE_DEPTH];
    logic [ppep_pkg::QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [ppep_pkg::QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [ppep_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head       = slot_reg[rptr_reg];
    assign empty      = (count_reg == '0);
    assign qstat.full = (count_reg == ppep_pkg::QCNT_W'(ppep_pkg::QUEUE_DEPTH));
    assign qstat.busy = !empty;

    // Pointer and fill bookkeeping
    always_comb begin
        wptr_next  = push ? wptr_reg + ppep_pkg::QPTR_W'(1) : wptr_reg;
        rptr_next  = pop  ? rptr_reg + ppep_pkg::QPTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ppep_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ppep_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_req;
        end
    end

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ppep_pkg::QCNT_W'(ppep_pkg::QUEUE_DEPTH))
        else $error("request queue overfilled");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("request queue popped while empty");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + ppep_pkg::QCNT_W'(1)))
        else $error("request queue count lost a push");
`endif

endmodule

[rtl/ppep_back.sv]
`timescale 1ns / 1ps

module ppep_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ppep_pkg::wr_t         wr,
    input  logic                  q_empty,
    input  ppep_pkg::req_t        head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_db_index,
    output logic [63:0]           m_key_hash,
    output logic [48:0]           m_value_offset,
    output logic [15:0]           m_value_length,
    output logic                  m_last_entry,
    output logic                  m_count_overflow
);

    logic [15:0]     idx_mem  [ppep_pkg::MAX_ENTRIES];
    logic [63:0]     hash_mem [ppep_pkg::MAX_ENTRIES];
    logic [15:0]     idx_rd_reg;
    logic [63:0]     hash_rd_reg;
    ppep_pkg::req_t  look_reg;
    logic            look_valid_reg, look_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_load;
    logic            look_adv;

    // Output register takes a new item when empty or being drained
    assign out_load = !out_valid_reg || m_ready;
    assign look_adv = look_valid_reg && out_load;
    assign pop      = !q_empty && (!look_valid_reg || out_load);

    // Header stores: written by the parser, read on pop
    always_ff @(posedge aclk) begin
        if (wr.idx_we) begin
            idx_mem[wr.addr] <= wr.idx_data;
        end
        if (wr.hash_we) begin
            hash_mem[wr.addr] <= wr.hash_data;
        end
        if (pop) begin
            idx_rd_reg  <= idx_mem[head.idx];
            hash_rd_reg <= hash_mem[head.idx];
        end
    end

    // Lookup stage payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            look_reg <= head;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (look_adv) begin
            m_db_index       <= idx_rd_reg;
            m_key_hash       <= hash_rd_reg;
            m_value_offset   <= look_reg.offset;
            m_value_length   <= look_reg.length;
            m_last_entry     <= look_reg.last;
            m_count_overflow <= look_reg.overflow;
        end
    end

    // Stage valid flags
    always_comb begin
        look_valid_next = pop ? 1'b1 : (look_adv ? 1'b0 : look_valid_reg);
        out_valid_next  = out_load ? look_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            look_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            look_valid_reg <= look_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_look_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (look_valid_reg && !out_load) |=> (look_valid_reg && $stable(look_reg)))
        else $error("lookup stage dropped a stalled item");
    a_pop_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> look_valid_reg)
        else $error("popped request never reached lookup stage");
    a_out_from_look: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(look_valid_reg))
        else $error("result appeared without a lookup");
`endif

endmodule

[rtl/packed_page_entry_parser_core.sv]
`timescale 1ns / 1ps

// Packed page entry parser.
// Input channel (s_*): one page byte per item, in page order. s_page_first
// marks byte 0 of a page; s_page_base is sampled with it. Bytes at page
// position PAGE_BYTES or beyond are dropped.
// Result channel (m_*): one item per entry whose length field completes,
// carrying the stored index and hash, the absolute value offset, the length,
// a last-entry flag and a count-overflow flag.
// Throughput: one byte per cycle while s_ready is high. A result passes from
// the request queue through the lookup stage (queue pop and header store
// read), then the output register.
// A 4-deep request queue sits between the byte parser and the store lookup.
// While lookups from an older page are still queued, the parser holds
// s_ready low on header bytes, which write the store; a stalled receiver
// thus backs up the queue and eventually stops byte intake.
// Reset (aresetn low, synchronous) empties the queue and pipeline and puts the
// parser at byte 0 of a page with base 0. The header stores are not cleared.

module packed_page_entry_parser_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    input  logic [47:0]  s_page_base,
    input  logic         s_page_first,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [15:0]  m_db_index,
    output logic [63:0]  m_key_hash,
    output logic [48:0]  m_value_offset,
    output logic [15:0]  m_value_length,
    output logic         m_last_entry,
    output logic         m_count_overflow
);

    ppep_pkg::req_t    push_req;
    ppep_pkg::req_t    head;
    ppep_pkg::wr_t     wr;
    ppep_pkg::qstat_t  qstat;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              hdr_phase;

    // Byte parser
    ppep_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_page_base  (s_page_base),
        .s_page_first (s_page_first),
        .qstat        (qstat),
        .push         (push),
        .push_req     (push_req),
        .wr           (wr),
        .hdr_phase    (hdr_phase)
    );

    // Pending result requests
    ppep_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .qstat    (qstat)
    );

    // Header store lookup and output register
    ppep_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .wr               (wr),
        .q_empty          (q_empty),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_db_index       (m_db_index),
        .m_key_hash       (m_key_hash),
        .m_value_offset   (m_value_offset),
        .m_value_length   (m_value_length),
        .m_last_entry     (m_last_entry),
        .m_count_overflow (m_count_overflow)
    );

`ifndef ASSERT_OFF
    a_no_write_under_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.idx_we || wr.hash_we) |-> q_empty)
        else $error("header store written while lookups pending");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !qstat.full)
        else $error("request pushed into a full queue");
    a_restart_no_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_page_first) |=> !hdr_phase)
        else $error("page restart did not return parser to count field");
`endif

endmodule

[tb/packed_page_entry_parser_core_tb.sv]
`timescale 1ns / 1ps

module packed_page_entry_parser_core_tb;

    // One emitted entry, laid out like the result ports
    typedef struct packed {
        logic [15:0] db_index;
        logic [63:0] key_hash;
        logic [48:0] value_offset;
        logic [15:0] value_length;
        logic        last_entry;
        logic        count_overflow;
    } entry_t;

    // Directed stimulus row; chk marks a row whose result is typed in
    typedef struct packed {
        logic        first;
        logic [47:0] base;
        logic [7:0]  data;
        logic        chk;
        entry_t      want;
    } dir_row_t;

    localparam entry_t NO_RES = '0;
    // Top base, one entry, every header and length byte 0xFF; length ends at byte 13
    localparam entry_t TOP_RES = '{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                   49'h1_0000_0000_000D, 16'hFFFF, 1'b1, 1'b0};
    localparam logic [47:0] BASE_TOP = 48'hFFFF_FFFF_FFFF;
    localparam int DIR_N = 23;
    localparam int TARGET_BYTES = 420;
    localparam int DRAIN_CYCLES = 20;

    localparam dir_row_t DIR_TAB [DIR_N] = '{
        // bytes ahead of any page mark: count 1, index 0x1234, one hash byte
        '{1'b0, 48'h5555_5555_5555, 8'h01, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'h00, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'h34, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'h12, 1'b0, NO_RES},
        '{1'b0, BASE_TOP,           8'hAB, 1'b0, NO_RES},
        // page mark mid-page at the top base: one entry, fields at maximum
        '{1'b1, BASE_TOP,           8'h01, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'h00, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hFF, 1'b1, TOP_RES},
        // trailing byte after the last entry is ignored
        '{1'b0, 48'h0,              8'h5A, 1'b0, NO_RES},
        // zero count at base 0: nothing emitted, rest ignored
        '{1'b1, 48'h0,              8'h00, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'h00, 1'b0, NO_RES},
        '{1'b0, 48'h0,              8'hC3, 1'b0, NO_RES}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic [47:0] s_page_base = '0;
    logic        s_page_first = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_db_index;
    logic [63:0] m_key_hash;
    logic [48:0] m_value_offset;
    logic [15:0] m_value_length;
    logic        m_last_entry;
    logic        m_count_overflow;

    // Typed expectation riding along with the current item
    logic   typed_row = 1'b0;
    entry_t typed_entry = '0;

    entry_t pending_entries[$];
    logic [7:0] page_bytes[$];
    int err_count = 0;
    int page_bytes_sent = 0;
    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int rcv_hold = 0;
    int cycle_cnt = 0;

    // Parser mirror state
    int unsigned       pos_next = 0;
    ppep_pkg::phase_t  ph = ppep_pkg::PH_COUNT;
    logic [15:0]       ent_total = '0;
    logic [15:0]       ent_cursor = '0;
    logic [63:0]       field_acc = '0;
    int                field_cnt = 0;
    logic [15:0]       skip_left = '0;
    logic [47:0]       base_held = '0;
    logic [15:0]       index_mem [ppep_pkg::MAX_ENTRIES];
    logic [63:0]       hash_mem [ppep_pkg::MAX_ENTRIES];

    packed_page_entry_parser_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_page_base     (s_page_base),
        .s_page_first    (s_page_first),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_db_index      (m_db_index),
        .m_key_hash      (m_key_hash),
        .m_value_offset  (m_value_offset),
        .m_value_length  (m_value_length),
        .m_last_entry    (m_last_entry),
        .m_count_overflow(m_count_overflow)
    );

    always #5 aclk = ~aclk;

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [47:0] rand_base();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return BASE_TOP;
            2: return BASE_TOP - 48'($urandom_range(0, 8191));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic void push16(input logic [15:0] v);
        page_bytes.push_back(v[7:0]);
        page_bytes.push_back(v[15:8]);
    endfunction

    function automatic void push64(input logic [63:0] v);
        for (int i = 0; i < 8; i++) page_bytes.push_back(v[8*i +: 8]);
    endfunction

    // Little-endian field assembly; returns 1 and the value once 'need' bytes are in
    function automatic bit field_done(input logic [7:0] b, input int need,
                                      output logic [63:0] v);
        field_acc |= 64'(b) << ((field_cnt & 7) * 8);
        field_cnt = (field_cnt + 1) & 15;
        v = field_acc;
        if (field_cnt < need) return 1'b0;
        field_acc = '0;
        field_cnt = 0;
        return 1'b1;
    endfunction

    // Advance the parser mirror by one page byte; 1 when an entry is emitted
    function automatic bit parse_byte(input logic first, input logic [47:0] base,
                                      input logic [7:0] b, output entry_t r);
        int unsigned p;
        int unsigned kept;
        logic [63:0] v;
        logic lst;
        r = '0;
        if (first) begin
            pos_next = 0;
            ph = ppep_pkg::PH_COUNT;
            ent_total = '0;
            ent_cursor = '0;
            skip_left = '0;
            base_held = base;
            field_acc = '0;
            field_cnt = 0;
        end
        // past the page end nothing moves
        if (pos_next >= ppep_pkg::PAGE_BYTES) return 1'b0;
        p = pos_next;
        pos_next = p + 1;
        case (ph)
            ppep_pkg::PH_COUNT: begin
                if (field_done(b, 2, v)) begin
                    ent_total = v[15:0];
                    ent_cursor = '0;
                    ph = (ent_total == 0) ? ppep_pkg::PH_DONE : ppep_pkg::PH_INDEX;
                end
            end
            ppep_pkg::PH_INDEX: begin
                if (field_done(b, 2, v)) begin
                    if (ent_cursor < ppep_pkg::MAX_ENTRIES) index_mem[ent_cursor] = v[15:0];
                    ph = ppep_pkg::PH_HASH;
                end
            end
            ppep_pkg::PH_HASH: begin
                if (field_done(b, 8, v)) begin
                    if (ent_cursor < ppep_pkg::MAX_ENTRIES) hash_mem[ent_cursor] = v;
                    ent_cursor = ent_cursor + 16'd1;
                    if (ent_cursor >= ent_total) begin
                        ent_cursor = '0;
                        ph = ppep_pkg::PH_LEN;
                    end else begin
                        ph = ppep_pkg::PH_INDEX;
                    end
                end
            end
            ppep_pkg::PH_LEN: begin
                if (field_done(b, 2, v)) begin
                    kept = (ent_total > ppep_pkg::MAX_ENTRIES) ? ppep_pkg::MAX_ENTRIES
                                                               : ent_total;
                    lst = (int'(ent_cursor) + 1 >= kept);
                    r.db_index = index_mem[(ent_cursor < ppep_pkg::MAX_ENTRIES) ?
                                           ent_cursor : 0];
                    r.key_hash = hash_mem[(ent_cursor < ppep_pkg::MAX_ENTRIES) ?
                                          ent_cursor : 0];
                    r.value_offset = 49'(base_held) + 49'(p) + 49'd1;
                    r.value_length = v[15:0];
                    r.last_entry = lst;
                    r.count_overflow = (ent_total > ppep_pkg::MAX_ENTRIES);
                    ent_cursor = ent_cursor + 16'd1;
                    if (lst) begin
                        ph = ppep_pkg::PH_DONE;
                    end else if (v[15:0] == 0) begin
                        ph = ppep_pkg::PH_LEN;
                    end else begin
                        skip_left = v[15:0];
                        ph = ppep_pkg::PH_SKIP;
                    end
                    return 1'b1;
                end
            end
            ppep_pkg::PH_SKIP: begin
                if (skip_left > 0) skip_left = skip_left - 16'd1;
                if (skip_left == 0) ph = ppep_pkg::PH_LEN;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 40) $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Drive one byte item, with an optional idle gap ahead of it
    task automatic put_byte(input logic first, input logic [47:0] base,
                            input logic [7:0] data, input logic chk, input entry_t want);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_page_first <= first;
        s_page_base <= base;
        s_data_byte <= data;
        typed_row <= chk;
        typed_entry <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_page(input logic [47:0] base, input bit mark, input bit counted);
        for (int i = 0; i < page_bytes.size(); i++)
            put_byte(mark && i == 0, base, page_bytes[i], 1'b0, NO_RES);
        if (counted) page_bytes_sent += page_bytes.size();
    endtask

    // Hold the sender until every expected entry has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_entries.size() != 0) @(posedge aclk);
    endtask

    // Well-formed page with n entries and random content
    task automatic build_page(input int n);
        int len;
        int r;
        page_bytes.delete();
        push16(16'(n));
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            push16(r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : 16'($urandom));
            push64({$urandom, $urandom});
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            len = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            push16(16'(len));
            for (int j = 0; j < len; j++) page_bytes.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) page_bytes.push_back(8'($urandom));
    endtask

    // Receiver stalls; the stall rate is redrawn whenever the low byte of cycle_cnt wraps to zero
    always @(posedge aclk) begin
        cycle_cnt++;
        if ((cycle_cnt & 255) == 0) begin
            case ($urandom_range(0, 2))
                0: rcv_stall_pct = 0;
                1: rcv_stall_pct = 10;
                default: rcv_stall_pct = 40;
            endcase
        end
        if (rcv_hold > 0) begin
            m_ready <= 1'b0;
            rcv_hold--;
        end else if ($urandom_range(0, 99) < rcv_stall_pct) begin
            m_ready <= 1'b0;
            rcv_hold = pick_gap() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Predict on accepted bytes, compare accepted results in order
    always @(posedge aclk) begin : result_check
        entry_t want;
        entry_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (parse_byte(s_page_first, s_page_base, s_data_byte, want) || typed_row) begin
                    if (typed_row) want = typed_entry;
                    pending_entries.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_db_index, m_key_hash, m_value_offset, m_value_length,
                        m_last_entry, m_count_overflow};
                if (pending_entries.size() == 0) begin
                    flag_error($sformatf("result with nothing expected: %h", got));
                end else begin
                    want = pending_entries.pop_front();
                    if (got.db_index !== want.db_index)
                        flag_error($sformatf("db_index %h, want %h",
                                             got.db_index, want.db_index));
                    if (got.key_hash !== want.key_hash)
                        flag_error($sformatf("key_hash %h, want %h",
                                             got.key_hash, want.key_hash));
                    if (got.value_offset !== want.value_offset)
                        flag_error($sformatf("value_offset %h, want %h",
                                             got.value_offset, want.value_offset));
                    if (got.value_length !== want.value_length)
                        flag_error($sformatf("value_length %h, want %h",
                                             got.value_length, want.value_length));
                    if (got.last_entry !== want.last_entry)
                        flag_error($sformatf("last_entry %b, want %b",
                                             got.last_entry, want.last_entry));
                    if (got.count_overflow !== want.count_overflow)
                        flag_error($sformatf("count_overflow %b, want %b",
                                             got.count_overflow, want.count_overflow));
                end
            end
        end
    end

    // Stimulus
    initial begin
        int kind;
        int pages;
        int len;
        pages = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        send_idle_pct = 30;
        foreach (DIR_TAB[i])
            put_byte(DIR_TAB[i].first, DIR_TAB[i].base, DIR_TAB[i].data,
                     DIR_TAB[i].chk, DIR_TAB[i].want);
        drain_results();

        // random pages: mostly well-formed, some cut short, zero-count or noise
        while (page_bytes_sent < TARGET_BYTES) begin
            case ($urandom_range(0, 3))
                0: send_idle_pct = 0;
                1: send_idle_pct = 10;
                default: send_idle_pct = 40;
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                page_bytes.delete();
                push16(16'h0000);
                repeat ($urandom_range(1, 3)) page_bytes.push_back(8'($urandom));
                send_page(rand_base(), 1'b1, 1'b1);
            end else if (kind < 12) begin
                page_bytes.delete();
                repeat ($urandom_range(1, 6)) page_bytes.push_back(8'($urandom));
                send_page(rand_base(), 1'b0, 1'b1);
            end else begin
                build_page(($urandom_range(0, 4) == 0) ? $urandom_range(7, 16)
                                                        : $urandom_range(1, 6));
                // broken page: a new page mark lands somewhere inside it
                if (kind < 24) begin
                    len = $urandom_range(1, page_bytes.size() - 1);
                    while (page_bytes.size() > len) void'(page_bytes.pop_back());
                end
                send_page(rand_base(), 1'b1, 1'b1);
            end
            pages++;
            if (pages % 8 == 0) drain_results();
        end

        // count above capacity: headers are walked, nothing is emitted
        send_idle_pct = 3;
        page_bytes.delete();
        push16(16'($urandom_range(ppep_pkg::MAX_ENTRIES + 1, 65535)));
        repeat ($urandom_range(30, 50)) page_bytes.push_back(8'($urandom));
        send_page(rand_base(), 1'b1, 1'b1);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("** packed_page_entry_parser_core: PASSED **");
        end else begin
            $display("** packed_page_entry_parser_core: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #40_000_000;
        $display("** packed_page_entry_parser_core: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/ppep_pkg.sv
rtl/ppep_front.sv
rtl/ppep_queue.sv
rtl/ppep_back.sv
rtl/packed_page_entry_parser_core.sv
tb/packed_page_entry_parser_core_tb.sv
